[sv/psu_pkg.sv]
// Shared types, constants and the DAC scaling function of the PSU output supervisor.
// Used by psu_csr and psu_output_supervisor; depends on nothing else.
`default_nettype none

package psu_pkg;

   // DAC resolution and the code at which scaling saturates.
   localparam int DAC_BITS      = 12;
   localparam int CODE_MAX      = (1 << DAC_BITS) - 1;

   // Register file geometry: seven 32-bit registers at byte addresses 4*i.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Reset values of the configuration registers.
   localparam logic [15:0]        VOLT_LIMIT_RESET    = 16'd30000;
   localparam logic [15:0]        CURR_LIMIT_RESET    = 16'd5000;
   localparam logic [15:0]        VOLT_GAIN_RESET     = 16'd10600;
   localparam logic [15:0]        CURR_GAIN_RESET     = 16'd16500;
   localparam logic signed [11:0] SHUTDOWN_TEMP_RESET = 12'sd850;
   localparam logic signed [11:0] RECOVER_TEMP_RESET  = 12'sd700;
   localparam logic [7:0]         SAVE_DELAY_RESET    = 8'd100;

   // Reset values of the supervisor state.
   localparam logic [15:0] VOLT_SET_RESET = 16'd3300;
   localparam logic [15:0] CURR_SET_RESET = 16'd100;

   // Command carried by one input beat.
   typedef enum logic [1:0] {
      MODE_TICK       = 2'd0,
      MODE_SET_VOLT   = 2'd1,
      MODE_SET_CURR   = 2'd2,
      MODE_SET_ENABLE = 2'd3
   } mode_type;

   // Register indexes, taken from paddr[4:2].
   typedef enum logic [2:0] {
      REG_VOLT_LIMIT    = 3'd0,
      REG_CURR_LIMIT    = 3'd1,
      REG_VOLT_GAIN     = 3'd2,
      REG_CURR_GAIN     = 3'd3,
      REG_SHUTDOWN_TEMP = 3'd4,
      REG_RECOVER_TEMP  = 3'd5,
      REG_SAVE_DELAY    = 3'd6
   } reg_index_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [15:0] voltage_limit_mv;
      logic [15:0] current_limit_ma;
      logic [15:0] voltage_gain;
      logic [15:0] current_gain;
      logic [11:0] shutdown_temp;
      logic [11:0] recover_temp;
      logic [7:0]  save_delay_ticks;
   } psu_cfg_type;

   // Scale a setpoint by a gain, drop 16 fraction bits and saturate to the DAC range.
   function automatic logic [DAC_BITS-1:0] dac_code(input logic [15:0] setpoint,
                                                    input logic [15:0] gain);
      logic [31:0] product;
      logic [15:0] scaled;
      product = 32'(setpoint) * 32'(gain);
      scaled  = product[31:16];
      if (scaled > 16'(CODE_MAX)) begin
         return DAC_BITS'(CODE_MAX);
      end
      return scaled[DAC_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

[sv/psu_csr.sv]
// APB-style configuration register file of the PSU output supervisor.
// Depends on psu_pkg for the register indexes, reset values and config struct.
`default_nettype none

module psu_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [psu_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [psu_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [psu_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                    csr_pready,
   output psu_pkg::psu_cfg_type                    cfg
);
   import psu_pkg::*;

   psu_cfg_type   cfg_ff;
   psu_cfg_type   cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write decode; an index past the last register is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_VOLT_LIMIT:    cfg_in.voltage_limit_mv = csr_pwdata[15:0];
            REG_CURR_LIMIT:    cfg_in.current_limit_ma = csr_pwdata[15:0];
            REG_VOLT_GAIN:     cfg_in.voltage_gain     = csr_pwdata[15:0];
            REG_CURR_GAIN:     cfg_in.current_gain     = csr_pwdata[15:0];
            REG_SHUTDOWN_TEMP: cfg_in.shutdown_temp    = csr_pwdata[11:0];
            REG_RECOVER_TEMP:  cfg_in.recover_temp     = csr_pwdata[11:0];
            REG_SAVE_DELAY:    cfg_in.save_delay_ticks = csr_pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voltage_limit_mv <= VOLT_LIMIT_RESET;
         cfg_ff.current_limit_ma <= CURR_LIMIT_RESET;
         cfg_ff.voltage_gain     <= VOLT_GAIN_RESET;
         cfg_ff.current_gain     <= CURR_GAIN_RESET;
         cfg_ff.shutdown_temp    <= SHUTDOWN_TEMP_RESET;
         cfg_ff.recover_temp     <= RECOVER_TEMP_RESET;
         cfg_ff.save_delay_ticks <= SAVE_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux; registers come back zero extended.
   always_comb begin
      case (index)
         REG_VOLT_LIMIT:    csr_prdata = CSR_DATA_BITS'(cfg_ff.voltage_limit_mv);
         REG_CURR_LIMIT:    csr_prdata = CSR_DATA_BITS'(cfg_ff.current_limit_ma);
         REG_VOLT_GAIN:     csr_prdata = CSR_DATA_BITS'(cfg_ff.voltage_gain);
         REG_CURR_GAIN:     csr_prdata = CSR_DATA_BITS'(cfg_ff.current_gain);
         REG_SHUTDOWN_TEMP: csr_prdata = CSR_DATA_BITS'(cfg_ff.shutdown_temp);
         REG_RECOVER_TEMP:  csr_prdata = CSR_DATA_BITS'(cfg_ff.recover_temp);
         REG_SAVE_DELAY:    csr_prdata = CSR_DATA_BITS'(cfg_ff.save_delay_ticks);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

[sv/psu_output_supervisor.sv]
// PSU output supervisor top level: input register, command datapath and result register.
// Depends on psu_pkg and psu_csr.
`default_nettype none

// The supervisor takes one command beat per cycle while req_stall is low and returns exactly
// one result beat per command. A beat passes an input register, combinational logic
// (setpoint clamp, state update and the two 16x16 DAC scaling multipliers) and a result
// register, so the sustained rate is one item per clock when the result side does not
// stall; a stalled result holds the input register, and only then does req_stall rise.
// Each result shows the state after its command. Configuration is to be written through
// the APB-style port only while no command is in flight; the block does not enforce this.
module psu_output_supervisor (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Command channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_mode,
   input  wire logic [15:0]                        req_value,
   input  wire logic signed [11:0]                 req_temperature,
   // Result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [psu_pkg::DAC_BITS-1:0]            rsp_voltage_code,
   output logic [psu_pkg::DAC_BITS-1:0]            rsp_current_code,
   output logic                                    rsp_output_on,
   output logic                                    rsp_over_temp,
   output logic [15:0]                             rsp_voltage_setpoint,
   output logic [15:0]                             rsp_current_setpoint,
   output logic signed [11:0]                      rsp_last_temperature,
   output logic                                    rsp_save_strobe,
   // Configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [psu_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [psu_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [psu_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                    csr_pready
);
   import psu_pkg::*;

   psu_cfg_type cfg;

   // Input register
   logic               in_vld_ff, in_vld_in;
   mode_type           mode_ff;
   logic [15:0]        value_ff;
   logic signed [11:0] temp_ff;

   // Supervisor state
   logic [15:0]        volt_set_ff, volt_set_in;
   logic [15:0]        curr_set_ff, curr_set_in;
   logic               enabled_ff, enabled_in;
   logic               hot_ff, hot_in;
   logic [7:0]         countdown_ff, countdown_in;
   logic signed [11:0] temp_reading_ff, temp_reading_in;
   logic               strobe;

   // Result register
   logic                out_vld_ff, out_vld_in;
   logic [DAC_BITS-1:0] volt_code_ff, curr_code_ff;
   logic                output_on_ff, over_temp_ff, strobe_ff;
   logic [15:0]         volt_set_out_ff, curr_set_out_ff;
   logic signed [11:0]  temp_out_ff;

   logic req_accept;
   logic advance;

   psu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake: a held beat moves on when the result register is free or being drained.
   assign advance    = in_vld_ff & (~out_vld_ff | ~rsp_stall);
   assign req_stall  = in_vld_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;
   assign in_vld_in  = req_accept | (in_vld_ff & ~advance);
   assign out_vld_in = advance | (out_vld_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Capture the command beat.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_value;
         temp_ff  <= req_temperature;
      end
   end

   // Command decode and next state.
   always_comb begin
      volt_set_in     = volt_set_ff;
      curr_set_in     = curr_set_ff;
      enabled_in      = enabled_ff;
      hot_in          = hot_ff;
      countdown_in    = countdown_ff;
      temp_reading_in = temp_reading_ff;
      strobe          = 1'b0;
      case (mode_ff)
         MODE_TICK: begin
            temp_reading_in = temp_ff;
            if (!hot_ff && temp_ff >= $signed(cfg.shutdown_temp)) begin
               hot_in     = 1'b1;
               enabled_in = 1'b0;
            end else if (hot_ff && temp_ff < $signed(cfg.recover_temp)) begin
               hot_in = 1'b0;
            end
            if (countdown_ff != 8'd0) begin
               countdown_in = countdown_ff - 8'd1;
               strobe       = (countdown_ff == 8'd1);
            end
         end
         MODE_SET_VOLT: begin
            volt_set_in  = (value_ff > cfg.voltage_limit_mv) ? cfg.voltage_limit_mv
                                                             : value_ff;
            countdown_in = cfg.save_delay_ticks;
         end
         MODE_SET_CURR: begin
            curr_set_in  = (value_ff > cfg.current_limit_ma) ? cfg.current_limit_ma
                                                             : value_ff;
            countdown_in = cfg.save_delay_ticks;
         end
         MODE_SET_ENABLE: begin
            // Enabling is refused during over-temperature; disabling always goes through.
            if (!(value_ff[0] && hot_ff)) begin
               enabled_in = value_ff[0];
            end
         end
         default: begin
            strobe = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_set_ff     <= VOLT_SET_RESET;
         curr_set_ff     <= CURR_SET_RESET;
         enabled_ff      <= 1'b0;
         hot_ff          <= 1'b0;
         countdown_ff    <= 8'd0;
         temp_reading_ff <= 12'sd0;
      end else if (advance) begin
         volt_set_ff     <= volt_set_in;
         curr_set_ff     <= curr_set_in;
         enabled_ff      <= enabled_in;
         hot_ff          <= hot_in;
         countdown_ff    <= countdown_in;
         temp_reading_ff <= temp_reading_in;
      end
   end

   // Result register, loaded from the updated state.
   always_ff @(posedge clock) begin
      if (advance) begin
         volt_code_ff    <= enabled_in ? dac_code(volt_set_in, cfg.voltage_gain)
                                       : '0;
         curr_code_ff    <= dac_code(curr_set_in, cfg.current_gain);
         output_on_ff    <= enabled_in;
         over_temp_ff    <= hot_in;
         volt_set_out_ff <= volt_set_in;
         curr_set_out_ff <= curr_set_in;
         temp_out_ff     <= temp_reading_in;
         strobe_ff       <= strobe;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_voltage_code     = volt_code_ff;
   assign rsp_current_code     = curr_code_ff;
   assign rsp_output_on        = output_on_ff;
   assign rsp_over_temp        = over_temp_ff;
   assign rsp_voltage_setpoint = volt_set_out_ff;
   assign rsp_current_setpoint = curr_set_out_ff;
   assign rsp_last_temperature = temp_out_ff;
   assign rsp_save_strobe      = strobe_ff;

`ifndef SYNTHESIS
   // The output is never on while the over-temperature lockout holds.
   a_no_on_when_hot: assert property (@(posedge clock) disable iff (reset)
      !(enabled_ff && hot_ff))
      else $error("output enabled during over-temperature lockout");

   // A disabled output always drives a zero voltage code.
   a_code_zero_when_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_output_on) |-> (rsp_voltage_code == '0))
      else $error("nonzero voltage code while output off");

   // A full pipeline facing a stalled result must stall the command side.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && out_vld_ff && rsp_stall) |-> req_stall)
      else $error("command accepted while both stages are blocked");

   // The save strobe only comes from a tick that counted down from one.
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      (advance && strobe) |=> (countdown_ff == 8'd0 && rsp_save_strobe))
      else $error("save strobe without countdown expiry");
`endif

endmodule

`default_nettype wire

[bench/psu_output_supervisor_tb.sv]
// Self-checking testbench for the PSU output supervisor: a queue-fed command driver,
// a result monitor with its own prediction of the supervisor state, and APB register writes.
// Depends on psu_pkg and the psu_output_supervisor RTL.
`default_nettype none

module psu_output_supervisor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psu_pkg::*;

   // Cycles without any accepted beat before the run is declared hung.
   localparam int QUIET_LIMIT = 5000;

   // One command beat waiting to be driven.
   typedef struct {
      mode_type           mode;
      logic [15:0]        value;
      logic signed [11:0] temperature;
   } supervisor_command_type;

   // One predicted result beat.
   typedef struct {
      logic [DAC_BITS-1:0] voltage_code;
      logic [DAC_BITS-1:0] current_code;
      logic                output_on;
      logic                over_temp;
      logic [15:0]         voltage_setpoint;
      logic [15:0]         current_setpoint;
      logic signed [11:0]  last_temperature;
      logic                save_strobe;
   } supply_status_type;

   // Clock, reset and all block inputs start at known values.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_mode = '0;
   logic [15:0]               req_value = '0;
   logic signed [11:0]        req_temperature = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [DAC_BITS-1:0]       rsp_voltage_code;
   logic [DAC_BITS-1:0]       rsp_current_code;
   logic                      rsp_output_on;
   logic                      rsp_over_temp;
   logic [15:0]               rsp_voltage_setpoint;
   logic [15:0]               rsp_current_setpoint;
   logic signed [11:0]        rsp_last_temperature;
   logic                      rsp_save_strobe;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   // Traffic shaping, set by the sequence between phases.
   int unsigned sender_idle_pct = 38;
   int unsigned receiver_idle_pct = 87;

   // Bench copy of the configuration registers.
   logic [15:0]        lim_volt;
   logic [15:0]        lim_curr;
   logic [15:0]        gain_volt;
   logic [15:0]        gain_curr;
   logic signed [11:0] trip_temp;
   logic signed [11:0] clear_temp;
   logic [7:0]         save_delay;

   // Bench copy of the supervisor state.
   logic [15:0]        vset;
   logic [15:0]        iset;
   logic               out_on;
   logic               is_hot;
   logic [7:0]         save_count;
   logic signed [11:0] temp_seen;

   supervisor_command_type command_backlog_q[$];
   supply_status_type      status_due_q[$];
   int                     mismatch_count = 0;
   int                     quiet_cycles = 0;

   psu_output_supervisor dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_value            (req_value),
      .req_temperature      (req_temperature),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_voltage_code     (rsp_voltage_code),
      .rsp_current_code     (rsp_current_code),
      .rsp_output_on        (rsp_output_on),
      .rsp_over_temp        (rsp_over_temp),
      .rsp_voltage_setpoint (rsp_voltage_setpoint),
      .rsp_current_setpoint (rsp_current_setpoint),
      .rsp_last_temperature (rsp_last_temperature),
      .rsp_save_strobe      (rsp_save_strobe),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   // Free-running clock.
   initial begin
      forever #1 clock = ~clock;
   end

   // Setpoint times gain, keep the integer part and saturate to the DAC range.
   function automatic logic [DAC_BITS-1:0] scale_to_code(input logic [15:0] setpoint,
                                                         input logic [15:0] gain);
      logic [31:0] product;
      product = 32'(setpoint) * 32'(gain);
      if (product[31:16] > 16'(CODE_MAX)) begin
         return DAC_BITS'(CODE_MAX);
      end
      return product[16 +: DAC_BITS];
   endfunction

   // Apply one accepted command to the bench state and queue the status it must produce.
   function automatic void advance_supervisor(input mode_type mode, input logic [15:0] value,
                                              input logic signed [11:0] temperature);
      supply_status_type status;
      logic              strobe;
      strobe = 1'b0;
      case (mode)
         MODE_TICK: begin
            temp_seen = temperature;
            if (!is_hot && temperature >= trip_temp) begin
               is_hot = 1'b1;
               out_on = 1'b0;
            end else if (is_hot && temperature < clear_temp) begin
               is_hot = 1'b0;
            end
            if (save_count != 8'd0) begin
               save_count = save_count - 8'd1;
               strobe = (save_count == 8'd0);
            end
         end
         MODE_SET_VOLT: begin
            vset = (value > lim_volt) ? lim_volt : value;
            save_count = save_delay;
         end
         MODE_SET_CURR: begin
            iset = (value > lim_curr) ? lim_curr : value;
            save_count = save_delay;
         end
         default: begin
            // An enable request is refused while over temperature; disabling always works.
            if (!(value[0] && is_hot)) begin
               out_on = value[0];
            end
         end
      endcase
      status.voltage_code     = out_on ? scale_to_code(vset, gain_volt) : '0;
      status.current_code     = scale_to_code(iset, gain_curr);
      status.output_on        = out_on;
      status.over_temp        = is_hot;
      status.voltage_setpoint = vset;
      status.current_setpoint = iset;
      status.last_temperature = temp_seen;
      status.save_strobe      = strobe;
      status_due_q.push_back(status);
   endfunction

   // Print one line per problem and count it.
   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%04h, expected 0x%04h", name, got, want));
      end
   endtask

   // Command driver: holds a stalled beat, otherwise takes the next command or idles.
   always @(posedge clock) begin : command_driver
      supervisor_command_type next_cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_supervisor(mode_type'(req_mode), req_value, req_temperature);
         end
         if (!req_valid || !req_stall) begin
            if (command_backlog_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_cmd = command_backlog_q.pop_front();
               req_mode        <= next_cmd.mode;
               req_value       <= next_cmd.value;
               req_temperature <= next_cmd.temperature;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted beat, drives stall and watches for a hang.
   always @(posedge clock) begin : status_monitor
      supply_status_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (status_due_q.size() == 0) begin
               report_mismatch("result beat with no command outstanding");
            end else begin
               want = status_due_q.pop_front();
               check_field("voltage_code", 16'(rsp_voltage_code), 16'(want.voltage_code));
               check_field("current_code", 16'(rsp_current_code), 16'(want.current_code));
               check_field("output_on", 16'(rsp_output_on), 16'(want.output_on));
               check_field("over_temp", 16'(rsp_over_temp), 16'(want.over_temp));
               check_field("voltage_setpoint", rsp_voltage_setpoint, want.voltage_setpoint);
               check_field("current_setpoint", rsp_current_setpoint, want.current_setpoint);
               check_field("last_temperature", 16'(rsp_last_temperature),
                           16'(want.last_temperature));
               check_field("save_strobe", 16'(rsp_save_strobe), 16'(want.save_strobe));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // One APB write: setup cycle, then access until pready; updates the bench copy.
   task automatic csr_write(input reg_index_type idx, input logic [15:0] field);
      logic [31:0] data;
      data = {16'($urandom), field};
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_VOLT_LIMIT:    lim_volt   = data[15:0];
         REG_CURR_LIMIT:    lim_curr   = data[15:0];
         REG_VOLT_GAIN:     gain_volt  = data[15:0];
         REG_CURR_GAIN:     gain_curr  = data[15:0];
         REG_SHUTDOWN_TEMP: trip_temp  = data[11:0];
         REG_RECOVER_TEMP:  clear_temp = data[11:0];
         default:           save_delay = data[7:0];
      endcase
   endtask

   task automatic write_all_registers(input logic [15:0] v_limit, input logic [15:0] c_limit,
                                      input logic [15:0] v_gain, input logic [15:0] c_gain,
                                      input logic signed [11:0] trip,
                                      input logic signed [11:0] clear,
                                      input logic [7:0] delay);
      csr_write(REG_VOLT_LIMIT, v_limit);
      csr_write(REG_CURR_LIMIT, c_limit);
      csr_write(REG_VOLT_GAIN, v_gain);
      csr_write(REG_CURR_GAIN, c_gain);
      csr_write(REG_SHUTDOWN_TEMP, 16'(trip));
      csr_write(REG_RECOVER_TEMP, 16'(clear));
      csr_write(REG_SAVE_DELAY, 16'(delay));
      @(negedge clock);
   endtask

   function automatic void push_command(input mode_type mode, input logic [15:0] value,
                                        input logic signed [11:0] temperature);
      supervisor_command_type cmd;
      cmd.mode        = mode;
      cmd.value       = value;
      cmd.temperature = temperature;
      command_backlog_q.push_back(cmd);
   endfunction

   // Half the readings span the full range, half sit near one of the thresholds.
   function automatic logic signed [11:0] pick_temperature();
      int t;
      if ($urandom_range(1) == 0) begin
         t = int'($urandom_range(2050)) - 550;
      end else begin
         t = ($urandom_range(1) ? int'(trip_temp) : int'(clear_temp))
             + int'($urandom_range(40)) - 20;
         if (t < -550) t = -550;
         if (t > 1500) t = 1500;
      end
      return 12'(t);
   endfunction

   // Setpoints: anything, just around the limit, or inside the limit.
   function automatic logic [15:0] pick_setpoint(input logic [15:0] limit);
      int pick;
      int t;
      pick = $urandom_range(99);
      if (pick < 30) begin
         return 16'($urandom);
      end else if (pick < 60) begin
         t = int'(limit) + int'($urandom_range(4)) - 2;
         if (t < 0) t = 0;
         if (t > 65535) t = 65535;
         return 16'(t);
      end
      return 16'($urandom_range(limit));
   endfunction

   // Random commands with runs of ticks long enough to let the save delay expire.
   function automatic void queue_random_commands(input int count);
      int made;
      int pick;
      int burst;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            push_command(MODE_TICK, 16'($urandom), pick_temperature());
            made++;
         end else if (pick < 60) begin
            push_command(MODE_SET_VOLT, pick_setpoint(lim_volt), pick_temperature());
            made++;
         end else if (pick < 75) begin
            push_command(MODE_SET_CURR, pick_setpoint(lim_curr), pick_temperature());
            made++;
         end else if (pick < 88) begin
            push_command(MODE_SET_ENABLE, {15'($urandom), 1'($urandom_range(99) < 70)},
                         pick_temperature());
            made++;
         end else begin
            burst = $urandom_range(1, int'(save_delay) + 2);
            repeat (burst) push_command(MODE_TICK, 16'($urandom), pick_temperature());
            made += burst;
         end
      end
   endfunction

   // Block until every queued command has been accepted and answered.
   task automatic wait_until_drained();
      while (command_backlog_q.size() != 0 || req_valid || status_due_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Test sequence: reset, directed commands, then random phases under different settings.
   initial begin
      lim_volt   = VOLT_LIMIT_RESET;
      lim_curr   = CURR_LIMIT_RESET;
      gain_volt  = VOLT_GAIN_RESET;
      gain_curr  = CURR_GAIN_RESET;
      trip_temp  = SHUTDOWN_TEMP_RESET;
      clear_temp = RECOVER_TEMP_RESET;
      save_delay = SAVE_DELAY_RESET;
      vset       = VOLT_SET_RESET;
      iset       = CURR_SET_RESET;
      out_on     = 1'b0;
      is_hot     = 1'b0;
      save_count = 8'd0;
      temp_seen  = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed commands at reset configuration.
      push_command(MODE_TICK, 16'hFFFF, 12'sd0);
      push_command(MODE_SET_ENABLE, 16'hFFFE, 12'sd1500);
      push_command(MODE_SET_ENABLE, 16'h0001, -12'sd550);
      push_command(MODE_SET_VOLT, 16'd0, 12'sd1500);
      push_command(MODE_SET_VOLT, 16'd65535, 12'sd0);
      push_command(MODE_SET_VOLT, 16'd30001, 12'sd0);
      push_command(MODE_SET_VOLT, 16'd30000, 12'sd0);
      push_command(MODE_SET_CURR, 16'd65535, 12'sd0);
      push_command(MODE_SET_CURR, 16'd0, 12'sd0);
      push_command(MODE_SET_CURR, 16'd5000, 12'sd0);
      push_command(MODE_TICK, 16'h0000, 12'sd849);
      // Reaching the trip point forces the output off.
      push_command(MODE_TICK, 16'h5A5A, 12'sd850);
      // Enabling while hot is refused.
      push_command(MODE_SET_ENABLE, 16'hFFFF, 12'sd0);
      push_command(MODE_TICK, 16'h0000, 12'sd700);
      push_command(MODE_TICK, 16'h0000, 12'sd699);
      push_command(MODE_SET_ENABLE, 16'h0001, 12'sd0);
      push_command(MODE_TICK, 16'h0000, 12'sd1500);
      // Disabling while hot is accepted.
      push_command(MODE_SET_ENABLE, 16'h0000, 12'sd0);
      push_command(MODE_TICK, 16'h0000, -12'sd550);
      push_command(MODE_SET_ENABLE, 16'h8001, -12'sd1);
      push_command(MODE_TICK, 16'hFFFF, -12'sd1);
      push_command(MODE_SET_VOLT, 16'd12345, 12'sd700);
      push_command(MODE_SET_CURR, 16'd4321, 12'sd850);
      queue_random_commands(400);
      wait_until_drained();

      // Largest limits and gains, widest thresholds, shortest save delay.
      write_all_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          12'sd1500, -12'sd550, 8'd1);
      sender_idle_pct   = 87;
      receiver_idle_pct = 38;
      queue_random_commands(400);
      wait_until_drained();

      // Zero limits and gains, crossed thresholds, longest save delay.
      write_all_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          -12'sd550, 12'sd1500, 8'd255);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      queue_random_commands(300);
      wait_until_drained();

      // Random settings with a short save delay.
      write_all_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          12'(int'($urandom_range(2050)) - 550),
                          12'(int'($urandom_range(2050)) - 550),
                          8'($urandom_range(2, 12)));
      queue_random_commands(450);
      wait_until_drained();

      // Let the pipeline settle before the verdict.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
